### hw/rtl/bba_pkg.sv
// ============================================================================
// bba_pkg
// Shared types and constants of the first-fit bitmap block allocator:
// operation and status codes, field widths and the control state encoding.
// ============================================================================
`default_nettype none

package bba_pkg;

    // field widths of the item channels and the limit register
    localparam int IDX_W    = 15;
    localparam int LIM_W    = 16;
    localparam int STATUS_W = 2;

    // widest map word supported, sets the width of a bit position
    localparam int WORD_BITS_CAP = 64;
    localparam int BIT_W         = $clog2(WORD_BITS_CAP);

    // largest index span that fits the granted index field
    localparam logic [LIM_W-1:0] INDEX_SPAN  = 16'd32768;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 16'd32000;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // control states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_AWR,
        S_FDIV,
        S_FRD,
        S_FWR,
        S_HOLD
    } t_state;

    // result of the search inside one map word
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] bit_pos;
    } t_find;

endpackage

`default_nettype wire

### hw/rtl/bba_req_if.sv
// ============================================================================
// bba_req_if
// Request channel: operation and block index with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bba_req_if;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [bba_pkg::IDX_W-1:0] block_index;

    modport source (output valid, output operation, output block_index, input ready);
    modport sink   (input valid, input operation, input block_index, output ready);

endinterface

`default_nettype wire

### hw/rtl/bba_rsp_if.sv
// ============================================================================
// bba_rsp_if
// Response channel: granted index and status with a valid/ready handshake.
// ============================================================================
`default_nettype none

interface bba_rsp_if;

    logic                         valid;
    logic                         ready;
    logic [bba_pkg::IDX_W-1:0]    granted_index;
    logic [bba_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_index, output status, input ready);
    modport sink   (input valid, input granted_index, input status, output ready);

endinterface

`default_nettype wire

### hw/rtl/bba_map_ram.sv
// ============================================================================
// bba_map_ram
// Usage map storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module bba_map_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/bba_first_clear.sv
// ============================================================================
// bba_first_clear
// Finds the lowest clear bit of one map word among the bits that lie below
// the block limit, optionally skipping the reserved block in bit 0.
// ============================================================================
`default_nettype none

module bba_first_clear #(
    parameter int WIDTH = 32
) (
    input  wire logic [WIDTH-1:0]          i_word,
    input  wire logic [bba_pkg::LIM_W-1:0] i_remain,
    input  wire logic                      i_skip0,
    output bba_pkg::t_find                 o_find
);

    logic [WIDTH-1:0] free_bits;

    // candidate bits: clear, below the limit, not the reserved block
    always_comb begin
        for (int b = 0; b < WIDTH; b++) begin
            free_bits[b] = !i_word[b] && (bba_pkg::LIM_W'(b) < i_remain);
        end
        if (i_skip0) begin
            free_bits[0] = 1'b0;
        end
    end

    // lowest candidate wins
    always_comb begin
        o_find.found   = |free_bits;
        o_find.bit_pos = '0;
        for (int b = WIDTH - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                o_find.bit_pos = bba_pkg::BIT_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bitmap_block_allocator.sv
// ============================================================================
// bitmap_block_allocator
// First-fit bitmap block allocator. The usage map sits in one synchronous
// memory; allocate scans it word by word for the lowest free block, free
// clears one bit by read-modify-write.
// ============================================================================
//
//  channel   dir  handshake      payload
//  i_req     in   valid/ready    operation, block_index
//  o_rsp     out  valid/ready    granted_index, status
//  cfg       in   i_cfg_we       i_cfg_wdata (block_limit)
//
//  allocate: scans the map words from word 0 up to the limit, one read a cycle;
//    a full map returns ST_FULL
//  free: reciprocal product, read, write back, result
//  after reset a clearing pass writes every map word (1024 at defaults),
//    with i_req.ready low
//  a waiting result in the output register does not block the next request;
//    a finished item waits only until that register is free
// ============================================================================
`default_nettype none

module bitmap_block_allocator #(
    parameter int MAX_BLOCKS    = 32768,
    parameter int MAP_WORD_BITS = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    bba_req_if.sink                        i_req,
    bba_rsp_if.source                      o_rsp,
    input  wire logic                      i_cfg_we,
    input  wire logic [bba_pkg::LIM_W-1:0] i_cfg_wdata
);

    localparam int MAP_DEPTH = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LIM_W     = bba_pkg::LIM_W;
    localparam int IDX_W     = bba_pkg::IDX_W;
    localparam int BIT_W     = bba_pkg::BIT_W;

    // limit cap: map size and index field span
    localparam logic [LIM_W-1:0] LIM_CAP = (MAX_BLOCKS < 32768) ?
                                           LIM_W'(MAX_BLOCKS) : bba_pkg::INDEX_SPAN;

    // word/bit split of an index by multiplication with a rounded-up reciprocal
    localparam int DIV_L  = $clog2(MAP_WORD_BITS);
    localparam int DIV_SH = IDX_W + DIV_L;
    localparam logic [16:0] RECIP = 17'(((1 << DIV_SH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS);

    localparam logic [LIM_W-1:0] WORD_STEP = LIM_W'(MAP_WORD_BITS);

    // registers
    bba_pkg::t_state               r_state, n_state;
    logic [ADDR_W-1:0]             r_clr_addr, n_clr_addr;
    logic [LIM_W-1:0]              r_limit;
    logic [IDX_W-1:0]              r_idx, n_idx;
    logic [31:0]                   r_prod, n_prod;
    logic [ADDR_W-1:0]             r_fword, n_fword;
    logic [BIT_W-1:0]              r_fbit, n_fbit;
    logic [ADDR_W-1:0]             r_issue_word, n_issue_word;
    logic [LIM_W-1:0]              r_issue_base, n_issue_base;
    logic                          r_chk_valid, n_chk_valid;
    logic [ADDR_W-1:0]             r_chk_word, n_chk_word;
    logic [LIM_W-1:0]              r_chk_base, n_chk_base;
    logic [ADDR_W-1:0]             r_wword, n_wword;
    logic [MAP_WORD_BITS-1:0]      r_wdata, n_wdata;
    logic [IDX_W-1:0]              r_res_grant, n_res_grant;
    logic [bba_pkg::STATUS_W-1:0]  r_res_status, n_res_status;
    logic                          r_out_valid, n_out_valid;
    logic [IDX_W-1:0]              r_out_grant, n_out_grant;
    logic [bba_pkg::STATUS_W-1:0]  r_out_status, n_out_status;

    // combinational
    logic [LIM_W-1:0]              eff_lim;
    logic                          issue;
    logic [LIM_W-1:0]              chk_remain;
    bba_pkg::t_find                find;
    logic [LIM_W-1:0]              grant_sum;
    logic [31:0]                   prod_sh;
    logic [IDX_W-1:0]              fq;
    logic [IDX_W-1:0]              fq_mul;
    logic [IDX_W-1:0]              frem;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [MAP_WORD_BITS-1:0]      mem_wdata;
    logic                          mem_re;
    logic [ADDR_W-1:0]             mem_raddr;
    logic [MAP_WORD_BITS-1:0]      mem_rdata;

    // usage map
    bba_map_ram #(
        .DEPTH  (MAP_DEPTH),
        .WIDTH  (MAP_WORD_BITS),
        .ADDR_W (ADDR_W)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // search of the word returned by the map
    assign chk_remain = eff_lim - r_chk_base;

    bba_first_clear #(
        .WIDTH (MAP_WORD_BITS)
    ) u_find (
        .i_word   (mem_rdata),
        .i_remain (chk_remain),
        .i_skip0  (r_chk_base == '0),
        .o_find   (find)
    );

    // effective limit and scan helpers
    assign eff_lim   = (r_limit > LIM_CAP) ? LIM_CAP : r_limit;
    assign issue     = (r_issue_base < eff_lim);
    assign grant_sum = r_chk_base + LIM_W'(find.bit_pos);

    // word and bit of the block to free
    assign prod_sh = r_prod >> DIV_SH;
    assign fq      = prod_sh[IDX_W-1:0];
    assign fq_mul  = IDX_W'(fq * IDX_W'(MAP_WORD_BITS));
    assign frem    = r_idx - fq_mul;

    // output channel
    assign i_req.ready         = (r_state == bba_pkg::S_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted_index = r_out_grant;
    assign o_rsp.status        = r_out_status;

    // next state, memory control and datapath
    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_fword      = r_fword;
        n_fbit       = r_fbit;
        n_issue_word = r_issue_word;
        n_issue_base = r_issue_base;
        n_chk_valid  = 1'b0;
        n_chk_word   = r_chk_word;
        n_chk_base   = r_chk_base;
        n_wword      = r_wword;
        n_wdata      = r_wdata;
        n_res_grant  = r_res_grant;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_grant  = r_out_grant;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_wword;
        mem_wdata    = r_wdata;
        mem_re       = 1'b0;
        mem_raddr    = r_issue_word;

        case (r_state)
            // zero the map one word a cycle
            bba_pkg::S_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(MAP_DEPTH - 1)) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end

            // take a request
            bba_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_res_grant = '0;
                    if (i_req.operation == bba_pkg::OP_ALLOC) begin
                        if (eff_lim <= LIM_W'(1)) begin
                            n_res_status = bba_pkg::ST_FULL;
                            n_state      = bba_pkg::S_HOLD;
                        end else begin
                            n_issue_word = '0;
                            n_issue_base = '0;
                            n_state      = bba_pkg::S_SCAN;
                        end
                    end else begin
                        if (LIM_W'(i_req.block_index) >= eff_lim) begin
                            n_res_status = bba_pkg::ST_RANGE;
                            n_state      = bba_pkg::S_HOLD;
                        end else if (i_req.block_index == '0) begin
                            n_res_status = bba_pkg::ST_OK;
                            n_state      = bba_pkg::S_HOLD;
                        end else begin
                            n_idx        = i_req.block_index;
                            n_res_status = bba_pkg::ST_OK;
                            n_state      = bba_pkg::S_FDIV;
                        end
                    end
                end
            end

            // pipelined scan: issue one word while checking the previous one
            bba_pkg::S_SCAN: begin
                mem_re    = issue;
                mem_raddr = r_issue_word;
                if (r_chk_valid && find.found) begin
                    n_wword      = r_chk_word;
                    n_wdata      = mem_rdata |
                                   (MAP_WORD_BITS'(1) << find.bit_pos);
                    n_res_grant  = grant_sum[IDX_W-1:0];
                    n_res_status = bba_pkg::ST_OK;
                    n_state      = bba_pkg::S_AWR;
                end else if (!r_chk_valid && !issue) begin
                    n_res_grant  = '0;
                    n_res_status = bba_pkg::ST_FULL;
                    n_state      = bba_pkg::S_HOLD;
                end else begin
                    n_chk_valid = issue;
                    n_chk_word  = r_issue_word;
                    n_chk_base  = r_issue_base;
                    if (issue) begin
                        n_issue_word = r_issue_word + ADDR_W'(1);
                        n_issue_base = r_issue_base + WORD_STEP;
                    end
                end
            end

            // mark the granted block in use
            bba_pkg::S_AWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_wword;
                mem_wdata = r_wdata;
                n_state   = bba_pkg::S_HOLD;
            end

            // reciprocal product for the word index
            bba_pkg::S_FDIV: begin
                n_prod  = 32'(r_idx) * 32'(RECIP);
                n_state = bba_pkg::S_FRD;
            end

            // read the word holding the block
            bba_pkg::S_FRD: begin
                mem_re    = 1'b1;
                mem_raddr = ADDR_W'(fq);
                n_fword   = ADDR_W'(fq);
                n_fbit    = frem[BIT_W-1:0];
                n_state   = bba_pkg::S_FWR;
            end

            // clear the bit and write back
            bba_pkg::S_FWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_fword;
                mem_wdata = mem_rdata & ~(MAP_WORD_BITS'(1) << r_fbit);
                n_state   = bba_pkg::S_HOLD;
            end

            // hand the result to the output register
            bba_pkg::S_HOLD: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_grant  = r_res_grant;
                    n_out_status = r_res_status;
                    n_state      = bba_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_CLEAR;
            r_clr_addr  <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // block limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bba_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_fword      <= n_fword;
        r_fbit       <= n_fbit;
        r_issue_word <= n_issue_word;
        r_issue_base <= n_issue_base;
        r_chk_word   <= n_chk_word;
        r_chk_base   <= n_chk_base;
        r_wword      <= n_wword;
        r_wdata      <= n_wdata;
        r_res_grant  <= n_res_grant;
        r_res_status <= n_res_status;
        r_out_grant  <= n_out_grant;
        r_out_status <= n_out_status;
    end

endmodule

`default_nettype wire

### bench/tb.sv
// ============================================================================
// tb
// Testbench of the first-fit bitmap block allocator. Directed requests cover
// the block limit corners: zero, one, two, the reset value, the index span and
// a value above it. Random allocate/free bursts then run under a range of
// limits. A behavioral copy of the free map predicts every result.
// ============================================================================
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BLOCKS = 32768;
    localparam int MAP_WORD_BITS = 32;
    localparam int TIMEOUT_NS = 50_000_000;

    typedef struct packed {
        logic [bba_pkg::IDX_W-1:0]    granted_index;
        logic [bba_pkg::STATUS_W-1:0] status;
    } t_grant;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [bba_pkg::LIM_W-1:0] i_cfg_wdata = '0;

    logic                      req_valid = 1'b0;
    logic                      req_op    = bba_pkg::OP_ALLOC;
    logic [bba_pkg::IDX_W-1:0] req_index = '0;
    logic                      rsp_ready = 1'b0;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();

    assign req_if.valid       = req_valid;
    assign req_if.operation   = req_op;
    assign req_if.block_index = req_index;
    assign rsp_if.ready       = rsp_ready;

    bitmap_block_allocator #(
        .MAX_BLOCKS    (MAX_BLOCKS),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // shadow of the free map and the limit register
    bit                        block_in_use [MAX_BLOCKS];
    logic [bba_pkg::LIM_W-1:0] limit_shadow = bba_pkg::LIMIT_RESET;
    t_grant                    expected_grants [$];

    bit steady     = 1'b0;
    int stall_left = 0;
    int errors     = 0;
    int n_items    = 0;
    int n_grants   = 0;
    int n_full     = 0;
    int n_range    = 0;
    int n_settings = 0;

    always #5 i_clk = ~i_clk;

    // limit actually in force: capped at the map size and the index span
    function automatic int usable_limit();
        int lim;
        lim = limit_shadow;
        if (lim > MAX_BLOCKS) lim = MAX_BLOCKS;
        if (lim > int'(bba_pkg::INDEX_SPAN)) lim = int'(bba_pkg::INDEX_SPAN);
        return lim;
    endfunction

    // apply one request to the shadow map and return the result it gives
    function automatic t_grant predict_grant(input logic op,
                                             input logic [bba_pkg::IDX_W-1:0] idx);
        t_grant g;
        int lim;
        lim = usable_limit();
        g.granted_index = '0;
        if (op == bba_pkg::OP_ALLOC) begin
            g.status = bba_pkg::ST_FULL;
            for (int i = 1; i < lim; i++) begin
                if (!block_in_use[i]) begin
                    block_in_use[i] = 1'b1;
                    g.granted_index = bba_pkg::IDX_W'(i);
                    g.status = bba_pkg::ST_OK;
                    break;
                end
            end
        end else if (int'(idx) >= lim) begin
            g.status = bba_pkg::ST_RANGE;
        end else begin
            // block zero is never marked, so freeing it changes nothing
            if (idx != 0) block_in_use[idx] = 1'b0;
            g.status = bba_pkg::ST_OK;
        end
        return g;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // free target: mostly a block in use, else any in range or any index
    function automatic logic [bba_pkg::IDX_W-1:0] pick_free_target();
        int lim;
        int r;
        int start;
        int k;
        lim = usable_limit();
        r = $urandom_range(0, 99);
        if (lim >= 2 && r < 70) begin
            start = $urandom_range(1, lim - 1);
            for (int n = 0; n < lim - 1; n++) begin
                k = 1 + (start - 1 + n) % (lim - 1);
                if (block_in_use[k]) return bba_pkg::IDX_W'(k);
            end
            return bba_pkg::IDX_W'(start);
        end
        if (lim >= 1 && r < 85) return bba_pkg::IDX_W'($urandom_range(0, lim - 1));
        return bba_pkg::IDX_W'($urandom_range(0, (1 << bba_pkg::IDX_W) - 1));
    endfunction

    // result side stalls
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            rsp_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    // compare each result with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_grant want;
        if (i_rst_n && rsp_if.valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected result: granted_index %0d status %0d",
                       rsp_if.granted_index, rsp_if.status);
                errors++;
            end else begin
                want = expected_grants.pop_front();
                if (rsp_if.granted_index !== want.granted_index) begin
                    $error("granted_index: expected %0d, got %0d",
                           want.granted_index, rsp_if.granted_index);
                    errors++;
                end
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    errors++;
                end
            end
        end
    end

    // one request item, predicted at acceptance, then a random gap
    task automatic send_request(input logic op, input logic [bba_pkg::IDX_W-1:0] idx);
        t_grant g;
        int gap;
        @(negedge i_clk);
        req_valid <= 1'b1;
        req_op <= op;
        req_index <= idx;
        do @(posedge i_clk); while (!req_if.ready);
        g = predict_grant(op, idx);
        expected_grants.push_back(g);
        n_items++;
        if (g.status == bba_pkg::ST_FULL) n_full++;
        else if (g.status == bba_pkg::ST_RANGE) n_range++;
        else if (op == bba_pkg::OP_ALLOC) n_grants++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // hold requests until every result is back and the block is idle
    task automatic wait_until_settled();
        @(negedge i_clk);
        req_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [bba_pkg::LIM_W-1:0] value);
        wait_until_settled();
        i_cfg_wdata <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        limit_shadow = value;
        n_settings++;
    endtask

    // alternating fill and drain bursts with random content
    task automatic run_traffic(input int count);
        int alloc_pct;
        int burst;
        alloc_pct = 0;
        burst = 0;
        steady = ($urandom_range(0, 3) == 0);
        for (int n = 0; n < count; n++) begin
            if (burst == 0) begin
                alloc_pct = (alloc_pct > 50) ? 25 : 85;
                burst = $urandom_range(10, 40);
                if ($urandom_range(0, 2) == 0) steady = !steady;
            end
            burst--;
            if ($urandom_range(0, 99) < alloc_pct)
                send_request(bba_pkg::OP_ALLOC, bba_pkg::IDX_W'($urandom));
            else
                send_request(bba_pkg::OP_FREE, pick_free_target());
        end
        steady = 1'b0;
    endtask

    // reset limit: first fit, reuse, block zero, double free, range edge
    task automatic test_default_limit();
        repeat (3) send_request(bba_pkg::OP_ALLOC, '0);
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(2));
        send_request(bba_pkg::OP_ALLOC, '1);
        send_request(bba_pkg::OP_FREE, '0);
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(2));
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(2));
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(bba_pkg::LIMIT_RESET - 1));
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(bba_pkg::LIMIT_RESET));
        send_request(bba_pkg::OP_FREE, '1);
        send_request(bba_pkg::OP_ALLOC, '0);
    endtask

    // limits of zero, one and two, the index span and above it
    task automatic test_small_limits();
        set_limit('0);
        send_request(bba_pkg::OP_ALLOC, '0);
        send_request(bba_pkg::OP_FREE, '0);
        set_limit(bba_pkg::LIM_W'(1));
        send_request(bba_pkg::OP_ALLOC, '1);
        send_request(bba_pkg::OP_FREE, '0);
        set_limit(bba_pkg::LIM_W'(2));
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(1));
        send_request(bba_pkg::OP_ALLOC, '0);
        send_request(bba_pkg::OP_ALLOC, '0);
        send_request(bba_pkg::OP_FREE, bba_pkg::IDX_W'(1));
        send_request(bba_pkg::OP_ALLOC, '0);
        set_limit('1);
        send_request(bba_pkg::OP_FREE, '1);
        send_request(bba_pkg::OP_ALLOC, '0);
        set_limit(bba_pkg::INDEX_SPAN);
        send_request(bba_pkg::OP_FREE, '1);
    endtask

    // random traffic under small limits so the map fills and empties
    task automatic test_random_limits();
        int lim;
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: lim = 2;
                1: lim = $urandom_range(3, 40);
                2: lim = $urandom_range(41, 160);
                3: lim = $urandom_range(161, 600);
                4: lim = $urandom_range(3, 64);
                default: lim = $urandom_range(3, 300);
            endcase
            set_limit(bba_pkg::LIM_W'(lim));
            run_traffic(125);
        end
    endtask

    // full index span and reset limit, with a pause until all results are back
    task automatic test_large_limit();
        set_limit(bba_pkg::INDEX_SPAN);
        run_traffic(90);
        wait_until_settled();
        run_traffic(40);
        set_limit(bba_pkg::LIMIT_RESET);
        run_traffic(70);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_limit();
        test_small_limits();
        test_random_limits();
        test_large_limit();

        wait_until_settled();
        repeat (40) @(posedge i_clk);

        $display("tb: %0d requests over %0d limit settings", n_items, n_settings);
        $display("tb: %0d grants, %0d full, %0d out-of-range frees",
                 n_grants, n_full, n_range);
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: timeout with %0d results outstanding", expected_grants.size());
        $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_req_if.sv
hw/rtl/bba_rsp_if.sv
hw/rtl/bba_map_ram.sv
hw/rtl/bba_first_clear.sv
hw/rtl/bitmap_block_allocator.sv
bench/tb.sv
